/* hdl/fbfa_pkg.sv */
`default_nettype none
package fbfa_pkg;

   localparam int LEN_BITS = 25;
   localparam int PART_COUNT = 5;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE = 2'd1;
   localparam logic [1:0] OP_TERM = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic CSR_FIT_POLICY = 1'b0;
   localparam logic CSR_MERGE_LIMIT = 1'b1;

   localparam logic [LEN_BITS-1:0] MERGE_LIMIT_RESET = 25'd4194304;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] process_id;
      logic [15:0] block_id;
      logic [24:0] request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] block_address;
      logic [5:0]  freed_count;
   } rsp_type;

   // boot partitions: 1, 2, 2, 4, 4 MB laid out from 3 MB
   function automatic logic [23:0] part_start(input logic [2:0] idx);
      logic [23:0] s;
      case (idx)
         3'd0: s = 24'd3145728;
         3'd1: s = 24'd4194304;
         3'd2: s = 24'd6291456;
         3'd3: s = 24'd8388608;
         3'd4: s = 24'd12582912;
         default: s = 24'd0;
      endcase
      return s;
   endfunction

   function automatic logic [LEN_BITS-1:0] part_len(input logic [2:0] idx);
      logic [LEN_BITS-1:0] l;
      case (idx)
         3'd0: l = 25'd1048576;
         3'd1: l = 25'd2097152;
         3'd2: l = 25'd2097152;
         3'd3: l = 25'd4194304;
         3'd4: l = 25'd4194304;
         default: l = 25'd0;
      endcase
      return l;
   endfunction

endpackage
`default_nettype wire

/* hdl/fbfa_merge.sv */
`default_nettype none
// One step of the coalescing pass: folds the next region into the open one
// or closes the open one and starts over with the next.
module fbfa_merge #(
   parameter int AW = 24,
   parameter int LW = 25
) (
   input  wire logic          have_cur,
   input  wire logic [AW-1:0] cur_start,
   input  wire logic [LW-1:0] cur_len,
   input  wire logic [AW-1:0] x_start,
   input  wire logic [LW-1:0] x_len,
   input  wire logic [LW-1:0] limit,
   output logic               emit,
   output logic [AW-1:0]      nxt_start,
   output logic [LW-1:0]      nxt_len
);
   localparam int EW = ((AW > LW) ? AW : LW) + 1;

   logic [EW-1:0] cur_end;
   logic [LW:0]   sum_len;
   logic          joinable;

   assign cur_end = EW'(cur_start) + EW'(cur_len);
   assign sum_len = {1'b0, cur_len} + {1'b0, x_len};
   assign joinable = have_cur && (cur_end == EW'(x_start)) && (sum_len <= {1'b0, limit});

   always_comb begin
      emit = have_cur && !joinable;
      if (joinable) begin
         nxt_start = cur_start;
         nxt_len = sum_len[LW-1:0];
      end else begin
         nxt_start = x_start;
         nxt_len = x_len;
      end
   end
endmodule
`default_nettype wire

/* hdl/first_best_fit_allocator_unit.sv */
`default_nettype none
// Channel   Ports                                   Moves
// request   req_valid / req_ready / req_data        one command per transaction
// response  rsp_valid / rsp_ready / rsp_data        one result per command
// csr       csr_we / csr_index / csr_data           register write, no wait
//
// One command at a time. Every table access is a read and then a use of the
// registered data, so allocate scans the free regions and moves in-use
// entries; free and terminate scan the in-use entries, rebuild the free list
// for each release and shift the in-use entries. After reset the boot
// partitions load while req_ready stays low. The result sits in an output
// register, so a stalled response holds only the next command.
module first_best_fit_allocator_unit #(
   parameter int FREE_DEPTH = 16,
   parameter int USED_DEPTH = 32,
   parameter int ADDR_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fbfa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fbfa_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [24:0]      csr_data
);
   localparam int AW = ADDR_BITS;
   localparam int LW = fbfa_pkg::LEN_BITS;
   localparam int FI = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int FC = $clog2(FREE_DEPTH + 2);
   localparam int UI = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
   localparam int UC = $clog2(USED_DEPTH + 1);
   localparam int FEW = AW + LW;
   localparam int UEW = AW + LW + 32;

   typedef enum logic [17:0] {
      S_INIT     = 18'h00001,
      S_IDLE     = 18'h00002,
      S_AL_RD    = 18'h00004,
      S_AL_EV    = 18'h00008,
      S_AL_CUT   = 18'h00010,
      S_AL_SH_RD = 18'h00020,
      S_AL_SH_WR = 18'h00040,
      S_US_PUT   = 18'h00080,
      S_US_SH_RD = 18'h00100,
      S_US_SH_WR = 18'h00200,
      S_SC_RD    = 18'h00400,
      S_SC_EV    = 18'h00800,
      S_REL_RD   = 18'h01000,
      S_REL_EL   = 18'h02000,
      S_REL_END  = 18'h04000,
      S_RM_RD    = 18'h08000,
      S_RM_WR    = 18'h10000,
      S_RESP     = 18'h20000
   } state_type;

   // free regions: two banks, the coalescing pass builds the new list in the
   // idle bank and the banks swap when it fits
   logic [FEW-1:0] free_mem [0:(2**(FI+1))-1];
   logic [UEW-1:0] used_mem [0:(2**UI)-1];

   state_type state_ff, state_in;
   logic bank_ff, bank_in;
   logic [FC-1:0] fn_ff, fn_in;
   logic [UC-1:0] uc_ff, uc_in;
   logic policy_ff, policy_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic rsp_valid_ff, rsp_valid_in;
   fbfa_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0] op_ff, op_in;
   logic [15:0] pid_ff, pid_in, tag_ff, tag_in;
   logic [LW-1:0] size_ff, size_in;
   logic found_ff, found_in;
   logic [FI-1:0] pick_ff, pick_in;
   logic [AW-1:0] pstart_ff, pstart_in;
   logic [LW-1:0] plen_ff, plen_in, best_ff, best_in;
   logic [FC-1:0] j_ff, j_in, m_ff, m_in;
   logic [UC-1:0] i_ff, i_in, k_ff, k_in;
   logic [AW-1:0] estart_ff, estart_in;
   logic [LW-1:0] elen_ff, elen_in;
   logic ins_ff, ins_in, have_ff, have_in;
   logic [AW-1:0] cs_ff, cs_in;
   logic [LW-1:0] cl_ff, cl_in;
   logic [1:0] st_ff, st_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [5:0] freed_ff, freed_in;

   logic fr_en, fw_en, ur_en, uw_en;
   logic [FI:0] fr_addr, fw_addr;
   logic [FEW-1:0] fw_data, fr_data_ff;
   logic [UI-1:0] ur_addr, uw_addr;
   logic [UEW-1:0] uw_data, ur_data_ff;

   logic feed_new;
   logic [AW-1:0] x_start, fr_start, ue_start;
   logic [LW-1:0] x_len, fr_len, ue_len, left;
   logic [15:0] ue_owner, ue_tag;
   logic mg_emit;
   logic [AW-1:0] mg_start;
   logic [LW-1:0] mg_len;

   assign fr_start = fr_data_ff[FEW-1:LW];
   assign fr_len = fr_data_ff[LW-1:0];
   assign ue_start = ur_data_ff[UEW-1:LW+32];
   assign ue_len = ur_data_ff[LW+31:32];
   assign ue_owner = ur_data_ff[31:16];
   assign ue_tag = ur_data_ff[15:0];
   assign left = fr_len - size_ff;

   assign x_start = feed_new ? estart_ff : fr_start;
   assign x_len = feed_new ? elen_ff : fr_len;

   fbfa_merge #(.AW(AW), .LW(LW)) u_merge (
      .have_cur (have_ff),
      .cur_start(cs_ff),
      .cur_len  (cl_ff),
      .x_start  (x_start),
      .x_len    (x_len),
      .limit    (limit_ff),
      .emit     (mg_emit),
      .nxt_start(mg_start),
      .nxt_len  (mg_len)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      fn_in = fn_ff;
      uc_in = uc_ff;
      policy_in = policy_ff;
      limit_in = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      op_in = op_ff;
      pid_in = pid_ff;
      tag_in = tag_ff;
      size_in = size_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pstart_in = pstart_ff;
      plen_in = plen_ff;
      best_in = best_ff;
      j_in = j_ff;
      m_in = m_ff;
      i_in = i_ff;
      k_in = k_ff;
      estart_in = estart_ff;
      elen_in = elen_ff;
      ins_in = ins_ff;
      have_in = have_ff;
      cs_in = cs_ff;
      cl_in = cl_ff;
      st_in = st_ff;
      addr_in = addr_ff;
      freed_in = freed_ff;
      feed_new = 1'b0;
      fr_en = 1'b0;
      fr_addr = '0;
      fw_en = 1'b0;
      fw_addr = '0;
      fw_data = '0;
      ur_en = 1'b0;
      ur_addr = '0;
      uw_en = 1'b0;
      uw_addr = '0;
      uw_data = '0;

      if (csr_we) begin
         unique case (csr_index)
            fbfa_pkg::CSR_FIT_POLICY: policy_in = csr_data[0];
            fbfa_pkg::CSR_MERGE_LIMIT: limit_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_INIT: begin
            fw_en = 1'b1;
            fw_addr = {1'b0, j_ff[FI-1:0]};
            fw_data = {AW'(fbfa_pkg::part_start(j_ff[2:0])), fbfa_pkg::part_len(j_ff[2:0])};
            j_in = j_ff + 1'b1;
            if (j_ff == FC'(fbfa_pkg::PART_COUNT - 1)) begin
               fn_in = FC'(fbfa_pkg::PART_COUNT);
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.operation;
               pid_in = req_data.process_id;
               tag_in = req_data.block_id;
               size_in = req_data.request_size;
               st_in = fbfa_pkg::ST_NOT_FOUND;
               addr_in = '0;
               freed_in = '0;
               j_in = '0;
               i_in = '0;
               found_in = 1'b0;
               best_in = '0;
               unique case (req_data.operation) inside
                  fbfa_pkg::OP_ALLOC: begin
                     if (req_data.request_size == '0) begin
                        st_in = fbfa_pkg::ST_NO_FIT;
                        state_in = S_RESP;
                     end else if (uc_ff >= UC'(USED_DEPTH)) begin
                        st_in = fbfa_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_AL_RD;
                     end
                  end
                  fbfa_pkg::OP_FREE, fbfa_pkg::OP_TERM: state_in = S_SC_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_AL_RD: begin
            if (j_ff < fn_ff) begin
               fr_en = 1'b1;
               fr_addr = {bank_ff, j_ff[FI-1:0]};
               state_in = S_AL_EV;
            end else if (found_ff) begin
               state_in = S_AL_CUT;
            end else begin
               st_in = fbfa_pkg::ST_NO_FIT;
               state_in = S_RESP;
            end
         end
         S_AL_EV: begin
            j_in = j_ff + 1'b1;
            state_in = S_AL_RD;
            if (fr_len >= size_ff && (!found_ff || (policy_ff && left < best_ff))) begin
               found_in = 1'b1;
               pick_in = j_ff[FI-1:0];
               best_in = left;
               pstart_in = fr_start;
               plen_in = fr_len;
               if (!policy_ff) state_in = S_AL_CUT;
            end
         end
         S_AL_CUT: begin
            addr_in = pstart_ff;
            if (plen_ff != size_ff) begin
               fw_en = 1'b1;
               fw_addr = {bank_ff, pick_ff};
               fw_data = {pstart_ff + AW'(size_ff), plen_ff - size_ff};
               state_in = S_US_PUT;
            end else begin
               j_in = FC'(pick_ff);
               state_in = S_AL_SH_RD;
            end
         end
         S_AL_SH_RD: begin
            // close the gap left by an emptied region
            if ({1'b0, j_ff} + 1'b1 < {1'b0, fn_ff}) begin
               fr_en = 1'b1;
               fr_addr = {bank_ff, FI'(j_ff + 1'b1)};
               state_in = S_AL_SH_WR;
            end else begin
               fn_in = fn_ff - 1'b1;
               state_in = S_US_PUT;
            end
         end
         S_AL_SH_WR: begin
            fw_en = 1'b1;
            fw_addr = {bank_ff, j_ff[FI-1:0]};
            fw_data = fr_data_ff;
            j_in = j_ff + 1'b1;
            state_in = S_AL_SH_RD;
         end
         S_US_PUT: begin
            // best fit appends, first fit pushes in at the front
            if (policy_ff) begin
               uw_en = 1'b1;
               uw_addr = uc_ff[UI-1:0];
               uw_data = {addr_ff, size_ff, pid_ff, tag_ff};
               uc_in = uc_ff + 1'b1;
               st_in = fbfa_pkg::ST_OK;
               state_in = S_RESP;
            end else begin
               k_in = uc_ff;
               state_in = S_US_SH_RD;
            end
         end
         S_US_SH_RD: begin
            if (k_ff != '0) begin
               ur_en = 1'b1;
               ur_addr = UI'(k_ff - 1'b1);
               state_in = S_US_SH_WR;
            end else begin
               uw_en = 1'b1;
               uw_addr = '0;
               uw_data = {addr_ff, size_ff, pid_ff, tag_ff};
               uc_in = uc_ff + 1'b1;
               st_in = fbfa_pkg::ST_OK;
               state_in = S_RESP;
            end
         end
         S_US_SH_WR: begin
            uw_en = 1'b1;
            uw_addr = k_ff[UI-1:0];
            uw_data = ur_data_ff;
            k_in = k_ff - 1'b1;
            state_in = S_US_SH_RD;
         end
         S_SC_RD: begin
            if (i_ff < uc_ff) begin
               ur_en = 1'b1;
               ur_addr = i_ff[UI-1:0];
               state_in = S_SC_EV;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SC_EV: begin
            if (ue_owner == pid_ff && (op_ff == fbfa_pkg::OP_TERM || ue_tag == tag_ff)) begin
               estart_in = ue_start;
               elen_in = ue_len;
               j_in = '0;
               m_in = '0;
               ins_in = 1'b0;
               have_in = 1'b0;
               state_in = S_REL_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SC_RD;
            end
         end
         S_REL_RD: begin
            if (j_ff < fn_ff) begin
               fr_en = 1'b1;
               fr_addr = {bank_ff, j_ff[FI-1:0]};
               state_in = S_REL_EL;
            end else if (!ins_ff) begin
               // freed block lies above every region
               feed_new = 1'b1;
               ins_in = 1'b1;
               have_in = 1'b1;
               cs_in = mg_start;
               cl_in = mg_len;
               if (mg_emit) begin
                  fw_en = (m_ff < FC'(FREE_DEPTH));
                  fw_addr = {~bank_ff, m_ff[FI-1:0]};
                  fw_data = {cs_ff, cl_ff};
                  m_in = m_ff + 1'b1;
               end
            end else begin
               fw_en = (m_ff < FC'(FREE_DEPTH));
               fw_addr = {~bank_ff, m_ff[FI-1:0]};
               fw_data = {cs_ff, cl_ff};
               m_in = m_ff + 1'b1;
               state_in = S_REL_END;
            end
         end
         S_REL_EL: begin
            // the freed block goes in ahead of the first region above it
            feed_new = !ins_ff && (fr_start > estart_ff);
            have_in = 1'b1;
            cs_in = mg_start;
            cl_in = mg_len;
            if (mg_emit) begin
               fw_en = (m_ff < FC'(FREE_DEPTH));
               fw_addr = {~bank_ff, m_ff[FI-1:0]};
               fw_data = {cs_ff, cl_ff};
               m_in = m_ff + 1'b1;
            end
            if (feed_new) begin
               ins_in = 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_REL_RD;
            end
         end
         S_REL_END: begin
            if (m_ff <= FC'(FREE_DEPTH)) begin
               bank_in = ~bank_ff;
               fn_in = m_ff;
               if (freed_ff == '0) addr_in = estart_ff;
               freed_in = freed_ff + 1'b1;
               st_in = fbfa_pkg::ST_OK;
               k_in = i_ff;
               state_in = S_RM_RD;
            end else begin
               st_in = fbfa_pkg::ST_FULL;
               state_in = S_RESP;
            end
         end
         S_RM_RD: begin
            if ({1'b0, k_ff} + 1'b1 < {1'b0, uc_ff}) begin
               ur_en = 1'b1;
               ur_addr = UI'(k_ff + 1'b1);
               state_in = S_RM_WR;
            end else begin
               uc_in = uc_ff - 1'b1;
               state_in = (op_ff == fbfa_pkg::OP_TERM) ? S_SC_RD : S_RESP;
            end
         end
         S_RM_WR: begin
            uw_en = 1'b1;
            uw_addr = k_ff[UI-1:0];
            uw_data = ur_data_ff;
            k_in = k_ff + 1'b1;
            state_in = S_RM_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = st_ff;
               rsp_in.block_address = addr_ff[23:0];
               rsp_in.freed_count = freed_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fw_en) free_mem[fw_addr] <= fw_data;
      if (fr_en) fr_data_ff <= free_mem[fr_addr];
      if (uw_en) used_mem[uw_addr] <= uw_data;
      if (ur_en) ur_data_ff <= used_mem[ur_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         bank_ff <= 1'b0;
         fn_ff <= '0;
         uc_ff <= '0;
         policy_ff <= 1'b0;
         limit_ff <= fbfa_pkg::MERGE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         fn_ff <= fn_in;
         uc_ff <= uc_in;
         policy_ff <= policy_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      op_ff <= op_in;
      pid_ff <= pid_in;
      tag_ff <= tag_in;
      size_ff <= size_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pstart_ff <= pstart_in;
      plen_ff <= plen_in;
      best_ff <= best_in;
      m_ff <= m_in;
      i_ff <= i_in;
      k_ff <= k_in;
      estart_ff <= estart_in;
      elen_ff <= elen_in;
      ins_ff <= ins_in;
      have_ff <= have_in;
      cs_ff <= cs_in;
      cl_ff <= cl_in;
      st_ff <= st_in;
      addr_ff <= addr_in;
      freed_ff <= freed_in;
   end
endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MB = 1048576;
   localparam int FREE_SLOTS = 16;
   localparam int USED_SLOTS = 32;
   localparam longint CYCLE_LIMIT = 30000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      fbfa_pkg::req_type r;
      bit      typed;
      fbfa_pkg::rsp_type e;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   fbfa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   fbfa_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [24:0] csr_data = '0;

   first_best_fit_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator shadow state
   logic        best_fit;
   logic [24:0] merge_cap;
   logic [23:0] fr_start[FREE_SLOTS];
   logic [24:0] fr_len[FREE_SLOTS];
   int          fr_cnt;
   logic [23:0] bk_start[USED_SLOTS];
   logic [24:0] bk_len[USED_SLOTS];
   logic [15:0] bk_pid[USED_SLOTS];
   logic [15:0] bk_tag[USED_SLOTS];
   int          bk_cnt;

   fbfa_pkg::rsp_type pending_rsp[$];
   plan_row_type plan[$];
   int  snd_idle_pct = 0;
   int  rcv_stall_pct = 0;
   int  errors = 0;
   longint cycles = 0;

   function automatic void shadow_reset();
      logic [23:0] a;
      a = 24'(3 * MB);
      best_fit = 1'b0;
      merge_cap = fbfa_pkg::MERGE_LIMIT_RESET;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         fr_start[i] = '0;
         fr_len[i] = '0;
      end
      for (int i = 0; i < fbfa_pkg::PART_COUNT; i++) begin
         fr_start[i] = a;
         fr_len[i] = (i == 0) ? 25'(MB) : (i < 3) ? 25'(2 * MB) : 25'(4 * MB);
         a = a + 24'(fr_len[i]);
      end
      fr_cnt = fbfa_pkg::PART_COUNT;
      bk_cnt = 0;
   endfunction

   // insert a freed block by address and merge neighbors; 0 if the list overflows
   function automatic bit return_block(logic [23:0] s, logic [24:0] l);
      logic [23:0] ts[FREE_SLOTS + 1];
      logic [24:0] tl[FREE_SLOTS + 1];
      int pos, j, m, i;
      longint fin, sum;
      pos = fr_cnt;
      j = 0;
      for (i = 0; i < fr_cnt; i++)
         if (fr_start[i] > s) begin
            pos = i;
            break;
         end
      for (i = 0; i <= fr_cnt; i++) begin
         if (i == pos) begin
            ts[i] = s;
            tl[i] = l;
         end else begin
            ts[i] = fr_start[j];
            tl[i] = fr_len[j];
            j++;
         end
      end
      m = fr_cnt + 1;
      i = 0;
      while (i + 1 < m) begin
         fin = longint'(ts[i]) + longint'(tl[i]);
         sum = longint'(tl[i]) + longint'(tl[i + 1]);
         if (fin == longint'(ts[i + 1]) && sum <= longint'(merge_cap)) begin
            tl[i] = 25'(sum);
            for (j = i + 1; j + 1 < m; j++) begin
               ts[j] = ts[j + 1];
               tl[j] = tl[j + 1];
            end
            m--;
         end else begin
            i++;
         end
      end
      if (m > FREE_SLOTS) return 1'b0;
      for (i = 0; i < FREE_SLOTS; i++) begin
         fr_start[i] = (i < m) ? ts[i] : '0;
         fr_len[i] = (i < m) ? tl[i] : '0;
      end
      fr_cnt = m;
      return 1'b1;
   endfunction

   function automatic void drop_block(int k);
      for (int i = k; i + 1 < bk_cnt; i++) begin
         bk_start[i] = bk_start[i + 1];
         bk_len[i] = bk_len[i + 1];
         bk_pid[i] = bk_pid[i + 1];
         bk_tag[i] = bk_tag[i + 1];
      end
      bk_cnt--;
   endfunction

   function automatic fbfa_pkg::rsp_type run_command(fbfa_pkg::req_type r);
      fbfa_pkg::rsp_type o;
      bit found;
      int pick, k, i, freed;
      logic [24:0] slack, left;
      o.status = fbfa_pkg::ST_NOT_FOUND;
      o.block_address = '0;
      o.freed_count = '0;
      freed = 0;
      if (r.operation == fbfa_pkg::OP_ALLOC) begin
         found = 0;
         pick = 0;
         slack = '0;
         if (r.request_size == 0) begin
            o.status = fbfa_pkg::ST_NO_FIT;
         end else if (bk_cnt >= USED_SLOTS) begin
            o.status = fbfa_pkg::ST_FULL;
         end else begin
            for (i = 0; i < fr_cnt; i++)
               if (fr_len[i] >= r.request_size) begin
                  left = fr_len[i] - r.request_size;
                  if (!found || (best_fit && left < slack)) begin
                     found = 1;
                     pick = i;
                     slack = left;
                     if (!best_fit) break;
                  end
               end
            if (!found) begin
               o.status = fbfa_pkg::ST_NO_FIT;
            end else begin
               o.block_address = fr_start[pick];
               fr_len[pick] = fr_len[pick] - r.request_size;
               fr_start[pick] = fr_start[pick] + 24'(r.request_size);
               if (fr_len[pick] == 0) begin
                  for (i = pick; i + 1 < fr_cnt; i++) begin
                     fr_start[i] = fr_start[i + 1];
                     fr_len[i] = fr_len[i + 1];
                  end
                  fr_cnt--;
                  fr_start[fr_cnt] = '0;
                  fr_len[fr_cnt] = '0;
               end
               if (best_fit) begin
                  k = bk_cnt;
               end else begin
                  for (i = bk_cnt; i > 0; i--) begin
                     bk_start[i] = bk_start[i - 1];
                     bk_len[i] = bk_len[i - 1];
                     bk_pid[i] = bk_pid[i - 1];
                     bk_tag[i] = bk_tag[i - 1];
                  end
                  k = 0;
               end
               bk_start[k] = o.block_address;
               bk_len[k] = r.request_size;
               bk_pid[k] = r.process_id;
               bk_tag[k] = r.block_id;
               bk_cnt++;
               o.status = fbfa_pkg::ST_OK;
            end
         end
      end else if (r.operation == fbfa_pkg::OP_FREE) begin
         for (i = 0; i < bk_cnt; i++)
            if (bk_pid[i] == r.process_id && bk_tag[i] == r.block_id) begin
               if (return_block(bk_start[i], bk_len[i])) begin
                  o.block_address = bk_start[i];
                  freed = 1;
                  o.status = fbfa_pkg::ST_OK;
                  drop_block(i);
               end else begin
                  o.status = fbfa_pkg::ST_FULL;
               end
               break;
            end
      end else if (r.operation == fbfa_pkg::OP_TERM) begin
         i = 0;
         while (i < bk_cnt) begin
            if (bk_pid[i] == r.process_id) begin
               if (!return_block(bk_start[i], bk_len[i])) begin
                  o.status = fbfa_pkg::ST_FULL;
                  break;
               end
               if (freed == 0) o.block_address = bk_start[i];
               freed++;
               o.status = fbfa_pkg::ST_OK;
               drop_block(i);
            end else begin
               i++;
            end
         end
      end
      o.freed_count = 6'(freed);
      return o;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [15:0] pid, logic [15:0] tag,
                                   logic [24:0] sz, bit typed, logic [1:0] st,
                                   logic [23:0] addr, logic [5:0] cnt);
      plan_row_type p;
      p.r = '{operation: op, process_id: pid, block_id: tag, request_size: sz};
      p.typed = typed;
      p.e = '{status: st, block_address: addr, freed_count: cnt};
      plan.insert(plan.size(), p);
   endfunction

   function automatic fbfa_pkg::req_type random_command();
      fbfa_pkg::req_type r;
      int k, pick;
      k = $urandom_range(99);
      r.operation = fbfa_pkg::OP_ALLOC;
      r.process_id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      r.block_id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      r.request_size = 25'($urandom_range(1, 262144));
      pick = (bk_cnt > 0) ? $urandom_range(bk_cnt - 1) : 0;
      if (k < 45) begin
         case ($urandom_range(19))
            0, 1, 2, 3: r.request_size = 25'($urandom_range(1, 4 * MB));
            4: if (fr_cnt > 0) r.request_size = fr_len[$urandom_range(fr_cnt - 1)];
            5: r.request_size = 25'($urandom);
            default: ;
         endcase
      end else if (k < 75) begin
         r.operation = fbfa_pkg::OP_FREE;
         if (bk_cnt > 0 && $urandom_range(99) < 85) begin
            r.process_id = bk_pid[pick];
            r.block_id = bk_tag[pick];
         end
         r.request_size = 25'($urandom);
      end else if (k < 90) begin
         r.operation = fbfa_pkg::OP_TERM;
         if (bk_cnt > 0 && $urandom_range(99) < 80) r.process_id = bk_pid[pick];
         r.block_id = 16'($urandom);
         r.request_size = 25'($urandom);
      end else begin
         r.operation = ($urandom_range(1) == 0) ? OP_UNUSED : 2'($urandom_range(2));
         r.process_id = 16'($urandom);
         r.block_id = 16'($urandom);
         r.request_size = 25'($urandom);
      end
      return r;
   endfunction

   task automatic issue(fbfa_pkg::req_type r, bit typed, fbfa_pkg::rsp_type e);
      fbfa_pkg::rsp_type p;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      p = run_command(r);
      pending_rsp.insert(pending_rsp.size(), typed ? e : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [24:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == fbfa_pkg::CSR_FIT_POLICY) best_fit = val[0];
      else merge_cap = val;
   endtask

   always @(posedge clock) begin
      fbfa_pkg::rsp_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.block_address !== e.block_address) begin
               $display("%0t: block_address exp %0h got %0h", $time,
                        e.block_address, rsp_data.block_address);
               errors++;
            end
            if (rsp_data.freed_count !== e.freed_count) begin
               $display("%0t: freed_count exp %0d got %0d", $time,
                        e.freed_count, rsp_data.freed_count);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   initial begin
      int fit_sel[4];
      int cap_sel[4];
      fbfa_pkg::rsp_type none;
      none = '0;
      fit_sel = '{0, 1, 0, 1};
      cap_sel = '{4 * MB, 16777216, 1, 2 * MB};
      shadow_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_row(fbfa_pkg::OP_ALLOC, 1, 1, 0, 1, fbfa_pkg::ST_NO_FIT, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 1, 1, 25'h1FFFFFF, 1, fbfa_pkg::ST_NO_FIT, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 1, 1, 16777216, 1, fbfa_pkg::ST_NO_FIT, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 1, 1, 25'(MB), 1, fbfa_pkg::ST_OK, 24'(3 * MB), 0);
      add_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 25'h1FFFFFF, 1, fbfa_pkg::ST_NOT_FOUND, 0, 0);
      add_row(fbfa_pkg::OP_FREE, 9, 9, 0, 1, fbfa_pkg::ST_NOT_FOUND, 0, 0);
      add_row(fbfa_pkg::OP_TERM, 9, 0, 0, 1, fbfa_pkg::ST_NOT_FOUND, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_FREE, 1, 1, 0, 1, fbfa_pkg::ST_OK, 24'(3 * MB), 1);
      add_row(fbfa_pkg::OP_ALLOC, 2, 1, 25'(4 * MB), 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 2, 2, 25'(4 * MB), 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 2, 3, 25'(2 * MB - 1), 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 3, 1, 25'(5 * MB), 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_TERM, 2, 16'hFFFF, 0, 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_FREE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_ALLOC, 0, 0, 1, 0, 0, 0, 0);
      add_row(fbfa_pkg::OP_FREE, 0, 0, 0, 0, 0, 0, 0);

      // reset settings first, then best fit, no merging, partial merging
      foreach (plan[i]) issue(plan[i].r, plan[i].typed, plan[i].e);
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_csr(fbfa_pkg::CSR_FIT_POLICY, 25'(fit_sel[ph]));
         write_csr(fbfa_pkg::CSR_MERGE_LIMIT, 25'(cap_sel[ph]));
         for (int idle = 0; idle < 4; idle++) begin
            snd_idle_pct = (idle == 1) ? 60 : (idle == 3) ? 24 : 0;
            rcv_stall_pct = (idle == 2) ? 60 : (idle == 3) ? 24 : 0;
            for (int n = 0; n < 34; n++) begin
               if (ph == 2 && idle == 1 && n == 17) drain();
               issue(random_command(), 0, none);
            end
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
